// ===== rtl/spza_pkg.sv =====
// Shared types and constants for the sonar proximity zone alarm.
package spza_pkg;

    localparam int NUM_SONARS = 4;
    localparam int DIR_W      = 2;
    localparam int RANGE_W    = 12;
    localparam int RANGE_MAX  = 4095;
    localparam int MASK_W     = 8;
    localparam int STATE_W    = 2;
    localparam int LED_W      = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_ALERT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_ALERT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = 2'd2;

    localparam logic [RANGE_W-1:0] FRONT_ALERT_RST = 12'd650;
    localparam logic [RANGE_W-1:0] SIDE_ALERT_RST  = 12'd150;
    localparam logic [RANGE_W-1:0] RANGE_LIMIT_RST = 12'd1000;

    localparam logic [DIR_W-1:0] DIR_FRONT = 2'd0;

    localparam logic [STATE_W-1:0] ZS_NONE   = 2'd0;
    localparam logic [STATE_W-1:0] ZS_WHITE  = 2'd1;
    localparam logic [STATE_W-1:0] ZS_YELLOW = 2'd2;
    localparam logic [STATE_W-1:0] ZS_RED    = 2'd3;

    localparam logic [MASK_W-1:0] YELLOW_BITS = 8'h55;
    localparam logic [MASK_W-1:0] RED_BITS    = 8'hAA;

    localparam logic [LED_W-1:0] LED_FULL = 8'd255;
    localparam logic [LED_W-1:0] LED_HALF = 8'd127;
    localparam logic [LED_W-1:0] LED_OFF  = 8'd0;

    typedef struct packed {
        logic [DIR_W-1:0]   direction;
        logic [RANGE_W-1:0] range_mm;
    } t_in_word;

    typedef struct packed {
        logic               alert;
        logic [LED_W-1:0]   led_red;
        logic [LED_W-1:0]   led_green;
        logic [MASK_W-1:0]  zone_mask;
        logic [STATE_W-1:0] zone_state;
    } t_out_word;

    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic [STATE_W-1:0] state;
    } t_zone_next;

endpackage

// ===== rtl/sonar_proximity_zone_alarm_top.sv =====
// Top level of the sonar proximity zone alarm: handshakes, config registers, output stage.
//
// Input channel: i_valid / o_stall carry one word (sonar direction, range in mm).
// Output channel: o_valid / i_stall carry one word per input word: alert flag,
// LED red and green levels, the 8-bit zone mask and the zone state.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx (front alert,
// side/rear alert, range limit); write only while the block is idle.
// A taken word waits in the compare stage and is then registered into the output stage.
// Throughput: one word per cycle while the output is not held; the window sum
// memory is read the cycle a word is taken and written back as it leaves the
// compare stage, with forwarding for a same-sonar word directly behind.
// Stall: when the output is held, the compare stage keeps its word and
// o_stall rises once that stage is full; nothing is dropped.
// Reset: synchronous, active low; window fill counts, mask and state clear,
// thresholds return to 650, 150 and 1000 mm. The sum memory needs no
// clearing pass: an empty window reads its sum as zero.
module sonar_proximity_zone_alarm_top #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  spza_pkg::t_in_word             i_word,
    output logic                           o_valid,
    input  logic                           i_stall,
    output spza_pkg::t_out_word            o_word,
    input  logic                           i_cfg_we,
    input  logic [spza_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spza_pkg::RANGE_W-1:0]   i_cfg_data
);

    localparam int SUM_W = $clog2(WINDOW_LEN*spza_pkg::RANGE_MAX+1);

    logic [spza_pkg::RANGE_W-1:0] r_front_alert;
    logic [spza_pkg::RANGE_W-1:0] r_side_alert;
    logic [spza_pkg::RANGE_W-1:0] r_limit;
    logic [spza_pkg::MASK_W-1:0]  r_mask;
    logic [spza_pkg::STATE_W-1:0] r_state;
    logic                         r_b_valid;
    logic [spza_pkg::DIR_W-1:0]   r_b_dir;
    logic                         r_o_valid;
    spza_pkg::t_out_word          r_o_word;

    logic                 n_b_valid;
    logic                 n_o_valid;
    spza_pkg::t_out_word  n_o_word;

    logic                 in_acc;
    logic                 o_adv;
    logic                 b_adv;
    logic [SUM_W-1:0]     win_sum;
    logic                 win_full;
    spza_pkg::t_zone_next zone_next;

    assign o_adv   = !r_o_valid || !i_stall;
    assign b_adv   = r_b_valid && o_adv;
    assign o_stall = r_b_valid && !o_adv;
    assign in_acc  = i_valid && !o_stall;

    spza_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_acc),
        .i_dir    (i_word.direction),
        .i_sample (i_word.range_mm),
        .i_commit (b_adv),
        .o_sum    (win_sum),
        .o_full   (win_full)
    );

    spza_zone #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_zone (
        .i_dir         (r_b_dir),
        .i_sum         (win_sum),
        .i_full        (win_full),
        .i_front_alert (r_front_alert),
        .i_side_alert  (r_side_alert),
        .i_limit       (r_limit),
        .i_mask        (r_mask),
        .i_state       (r_state),
        .o_next        (zone_next)
    );

    always_comb begin
        n_o_word.zone_mask  = zone_next.mask;
        n_o_word.zone_state = zone_next.state;
        if ((zone_next.mask & spza_pkg::RED_BITS) != '0) begin
            n_o_word.alert     = 1'b1;
            n_o_word.led_red   = spza_pkg::LED_FULL;
            n_o_word.led_green = spza_pkg::LED_OFF;
        end else if ((zone_next.mask & spza_pkg::YELLOW_BITS) != '0) begin
            n_o_word.alert     = 1'b0;
            n_o_word.led_red   = spza_pkg::LED_FULL;
            n_o_word.led_green = spza_pkg::LED_HALF;
        end else begin
            n_o_word.alert     = 1'b0;
            n_o_word.led_red   = spza_pkg::LED_OFF;
            n_o_word.led_green = spza_pkg::LED_OFF;
        end
    end

    always_comb begin
        if (in_acc) begin
            n_b_valid = 1'b1;
        end else if (b_adv) begin
            n_b_valid = 1'b0;
        end else begin
            n_b_valid = r_b_valid;
        end
        if (b_adv) begin
            n_o_valid = 1'b1;
        end else if (o_adv) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_alert <= spza_pkg::FRONT_ALERT_RST;
            r_side_alert  <= spza_pkg::SIDE_ALERT_RST;
            r_limit       <= spza_pkg::RANGE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spza_pkg::CFG_FRONT_ALERT: begin
                    r_front_alert <= i_cfg_data;
                end
                spza_pkg::CFG_SIDE_ALERT: begin
                    r_side_alert <= i_cfg_data;
                end
                spza_pkg::CFG_RANGE_LIMIT: begin
                    r_limit <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_mask    <= '0;
            r_state   <= spza_pkg::ZS_NONE;
        end else begin
            r_b_valid <= n_b_valid;
            r_o_valid <= n_o_valid;
            if (b_adv) begin
                r_mask  <= zone_next.mask;
                r_state <= zone_next.state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_dir <= i_word.direction;
        end
        if (b_adv) begin
            r_o_word <= n_o_word;
        end
    end

    assign o_valid = r_o_valid;
    assign o_word  = r_o_word;

`ifndef ASSERT_OFF
    a_take_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_b_valid)
        else $error("accepted word missing from compare stage");

    a_adv_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_adv |=> r_o_valid && (o_word.zone_mask == r_mask))
        else $error("output mask differs from committed mask");

    a_alert_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (o_word.alert == ((o_word.zone_mask & spza_pkg::RED_BITS) != '0)))
        else $error("alert flag inconsistent with zone mask");
`endif

endmodule

// ===== rtl/spza_window.sv =====
// Per-sonar sample ring and running sum held in memories, with write-back forwarding.
module spza_window #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [spza_pkg::DIR_W-1:0]   i_dir,
    input  logic [spza_pkg::RANGE_W-1:0] i_sample,
    input  logic                         i_commit,
    output logic [$clog2(WINDOW_LEN*spza_pkg::RANGE_MAX+1)-1:0] o_sum,
    output logic                         o_full
);

    localparam int SUM_W   = $clog2(WINDOW_LEN*spza_pkg::RANGE_MAX+1);
    localparam int FILL_W  = $clog2(WINDOW_LEN+1);
    localparam int PTR_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int DEPTH   = spza_pkg::NUM_SONARS*WINDOW_LEN;
    localparam int ADDR_W  = $clog2(DEPTH);

    logic [spza_pkg::RANGE_W-1:0] r_smp_mem [DEPTH];
    logic [SUM_W-1:0]             r_sum_mem [spza_pkg::NUM_SONARS];
    logic [PTR_W-1:0]             r_ptr     [spza_pkg::NUM_SONARS];
    logic [FILL_W-1:0]            r_fill    [spza_pkg::NUM_SONARS];

    logic [spza_pkg::RANGE_W-1:0] r_smp_rd;
    logic [SUM_W-1:0]             r_sum_rd;

    logic [spza_pkg::DIR_W-1:0]   r_dir;
    logic [spza_pkg::RANGE_W-1:0] r_val;
    logic [ADDR_W-1:0]            r_addr;
    logic                         r_first;
    logic                         r_old_full;
    logic                         r_now_full;
    logic                         r_fwd_sum;
    logic [SUM_W-1:0]             r_fwd_sum_val;
    logic                         r_fwd_smp;
    logic [spza_pkg::RANGE_W-1:0] r_fwd_smp_val;

    logic [PTR_W-1:0]  ld_ptr;
    logic [FILL_W-1:0] ld_fill;
    logic [ADDR_W-1:0] ld_addr;
    logic              ld_old_full;
    logic [SUM_W-1:0]  sum_base;
    logic [SUM_W-1:0]  sum_drop;
    logic [SUM_W-1:0]  new_sum;

    assign ld_ptr      = r_ptr[i_dir];
    assign ld_fill     = r_fill[i_dir];
    assign ld_old_full = (ld_fill == FILL_W'(WINDOW_LEN));
    assign ld_addr     = ADDR_W'(i_dir) * ADDR_W'(WINDOW_LEN) + ADDR_W'(ld_ptr);

    always_comb begin
        if (r_first) begin
            sum_base = '0;
        end else if (r_fwd_sum) begin
            sum_base = r_fwd_sum_val;
        end else begin
            sum_base = r_sum_rd;
        end
        if (!r_old_full) begin
            sum_drop = '0;
        end else if (r_fwd_smp) begin
            sum_drop = SUM_W'(r_fwd_smp_val);
        end else begin
            sum_drop = SUM_W'(r_smp_rd);
        end
        new_sum = sum_base - sum_drop + SUM_W'(r_val);
    end

    assign o_sum  = new_sum;
    assign o_full = r_now_full;

    // ring pointer and fill count advance as the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < spza_pkg::NUM_SONARS; k++) begin
                r_ptr[k]  <= '0;
                r_fill[k] <= '0;
            end
        end else if (i_load) begin
            r_ptr[i_dir] <= (ld_ptr == PTR_W'(WINDOW_LEN-1)) ? '0 : ld_ptr + PTR_W'(1);
            if (!ld_old_full) begin
                r_fill[i_dir] <= ld_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_smp_mem[r_addr] <= r_val;
        end
        if (i_load) begin
            r_smp_rd <= r_smp_mem[ld_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_sum_mem[r_dir] <= new_sum;
        end
        if (i_load) begin
            r_sum_rd <= r_sum_mem[i_dir];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_sum <= 1'b0;
            r_fwd_smp <= 1'b0;
        end else if (i_load) begin
            r_fwd_sum <= i_commit && (i_dir == r_dir);
            r_fwd_smp <= i_commit && (ld_addr == r_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dir         <= i_dir;
            r_val         <= i_sample;
            r_addr        <= ld_addr;
            r_first       <= (ld_fill == '0);
            r_old_full    <= ld_old_full;
            r_now_full    <= ld_old_full || (ld_fill == FILL_W'(WINDOW_LEN-1));
            r_fwd_sum_val <= new_sum;
            r_fwd_smp_val <= r_val;
        end
    end

endmodule

// ===== rtl/spza_zone.sv =====
// Zone decision: scaled threshold compare and mask/state update.
module spza_zone #(
    parameter int WINDOW_LEN = 5
) (
    input  logic [spza_pkg::DIR_W-1:0]   i_dir,
    input  logic [$clog2(WINDOW_LEN*spza_pkg::RANGE_MAX+1)-1:0] i_sum,
    input  logic                         i_full,
    input  logic [spza_pkg::RANGE_W-1:0] i_front_alert,
    input  logic [spza_pkg::RANGE_W-1:0] i_side_alert,
    input  logic [spza_pkg::RANGE_W-1:0] i_limit,
    input  logic [spza_pkg::MASK_W-1:0]  i_mask,
    input  logic [spza_pkg::STATE_W-1:0] i_state,
    output spza_pkg::t_zone_next         o_next
);

    localparam int SUM_W = $clog2(WINDOW_LEN*spza_pkg::RANGE_MAX+1);

    logic [spza_pkg::RANGE_W-1:0] alert_mm;
    logic [SUM_W-1:0]             alert_scaled;
    logic [SUM_W-1:0]             limit_scaled;
    logic [SUM_W-1:0]             s;
    logic [spza_pkg::MASK_W-1:0]  yel;
    logic [spza_pkg::MASK_W-1:0]  red;
    logic [spza_pkg::MASK_W-1:0]  pair;
    logic [spza_pkg::MASK_W-1:0]  m;
    logic [spza_pkg::STATE_W-1:0] st;

    assign alert_mm     = (i_dir == spza_pkg::DIR_FRONT) ? i_front_alert : i_side_alert;
    assign alert_scaled = SUM_W'(alert_mm) * SUM_W'(WINDOW_LEN);
    assign limit_scaled = SUM_W'(i_limit) * SUM_W'(WINDOW_LEN);
    assign s            = i_full ? i_sum : limit_scaled;
    assign yel          = spza_pkg::MASK_W'(1) << {i_dir, 1'b0};
    assign red          = spza_pkg::MASK_W'(2) << {i_dir, 1'b0};
    assign pair         = yel | red;

    always_comb begin
        m  = i_mask;
        st = i_state;
        if (s > alert_scaled && s < limit_scaled) begin
            if (i_dir == spza_pkg::DIR_FRONT) begin
                if ((m & red) != '0) begin
                    m = m & ~pair;
                end
                if ((m & spza_pkg::RED_BITS) == '0) begin
                    m  = (m & ~pair) | yel;
                    st = spza_pkg::ZS_YELLOW;
                end
            end else begin
                m = (m & ~pair) | yel;
                if ((m & spza_pkg::RED_BITS) == '0) begin
                    st = spza_pkg::ZS_YELLOW;
                end
            end
        end else if (s < alert_scaled) begin
            m  = m | red;
            st = spza_pkg::ZS_RED;
        end else begin
            m = m & ~pair;
            if (m == '0) begin
                st = spza_pkg::ZS_WHITE;
            end
        end
        o_next.mask  = m;
        o_next.state = st;
    end

endmodule

// ===== sim/sonar_proximity_zone_alarm_top_tb.sv =====
// Self-checking testbench for the sonar proximity zone alarm: directed table, then random phases.
module sonar_proximity_zone_alarm_top_tb;

    localparam int WIN       = 5;
    localparam int N_PHASES  = 6;
    localparam int PHASE_N   = 240;
    localparam int WD_LIMIT  = 4000;
    localparam int ROW_MAX   = 32;
    localparam int EXP_AW    = 6;
    localparam int EXP_DEPTH = 64;

    localparam logic [spza_pkg::DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [spza_pkg::DIR_W-1:0] DIR_REAR  = 2'd2;
    localparam logic [spza_pkg::DIR_W-1:0] DIR_LEFT  = 2'd3;

    localparam spza_pkg::t_out_word RES_WHITE =
        '{1'b0, spza_pkg::LED_OFF, spza_pkg::LED_OFF, 8'h00, spza_pkg::ZS_WHITE};
    localparam spza_pkg::t_out_word RES_FRONT_RED =
        '{1'b1, spza_pkg::LED_FULL, spza_pkg::LED_OFF, 8'h02, spza_pkg::ZS_RED};

    typedef struct {
        logic [spza_pkg::DIR_W-1:0]   dir;
        logic [spza_pkg::RANGE_W-1:0] rng;
        bit                           fixed;
        spza_pkg::t_out_word          res;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    spza_pkg::t_in_word             i_word;
    logic                           o_valid;
    logic                           i_stall;
    spza_pkg::t_out_word            o_word;
    logic                           i_cfg_we;
    logic [spza_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [spza_pkg::RANGE_W-1:0]   i_cfg_data;

    // zone predictor state
    logic [spza_pkg::RANGE_W-1:0] win_buf [spza_pkg::NUM_SONARS][WIN];
    int unsigned                  win_cnt [spza_pkg::NUM_SONARS];
    int unsigned                  win_sum [spza_pkg::NUM_SONARS];
    logic [spza_pkg::MASK_W-1:0]  zm;
    logic [spza_pkg::STATE_W-1:0] zst;
    logic [spza_pkg::RANGE_W-1:0] cfg_front, cfg_side, cfg_limit;

    spza_pkg::t_out_word exp_mem [EXP_DEPTH];
    logic [EXP_AW-1:0]   exp_wr, exp_rd;
    int                  exp_cnt;
    t_row                dir_rows [ROW_MAX];
    int                  n_rows;
    bit                  row_fixed;
    spza_pkg::t_out_word row_res;
    int                  snd_pct, rcv_pct;
    int                  n_taken, n_checked, n_bad, wd_cnt;
    logic [spza_pkg::DIR_W-1:0] dir_cur;

    sonar_proximity_zone_alarm_top #(.WINDOW_LEN(WIN)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_word     (o_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void zone_reset();
        int d, i;
        for (d = 0; d < spza_pkg::NUM_SONARS; d++) begin
            win_cnt[d] = 0;
            win_sum[d] = 0;
            for (i = 0; i < WIN; i++) win_buf[d][i] = '0;
        end
        zm        = '0;
        zst       = spza_pkg::ZS_NONE;
        cfg_front = spza_pkg::FRONT_ALERT_RST;
        cfg_side  = spza_pkg::SIDE_ALERT_RST;
        cfg_limit = spza_pkg::RANGE_LIMIT_RST;
    endfunction

    function automatic spza_pkg::t_out_word zone_predict(input spza_pkg::t_in_word w);
        int unsigned                 d, s, a5, l5;
        int                          i;
        logic [spza_pkg::MASK_W-1:0] yel, red, pair;
        spza_pkg::t_out_word         r;
        d    = w.direction;
        yel  = 8'h01 << (2 * d);
        red  = 8'h02 << (2 * d);
        pair = yel | red;
        if (win_cnt[d] >= WIN) win_sum[d] -= win_buf[d][WIN-1];
        else win_cnt[d]++;
        for (i = WIN - 1; i > 0; i--) win_buf[d][i] = win_buf[d][i-1];
        win_buf[d][0] = w.range_mm;
        win_sum[d] += w.range_mm;
        a5 = WIN * int'((d == spza_pkg::DIR_FRONT) ? cfg_front : cfg_side);
        l5 = WIN * int'(cfg_limit);
        s  = (win_cnt[d] < WIN) ? l5 : win_sum[d];
        if (s > a5 && s < l5) begin
            if (d == spza_pkg::DIR_FRONT) begin
                // front drops its own red before it may turn yellow
                if ((zm & red) != 0) zm = zm & ~pair;
                if ((zm & spza_pkg::RED_BITS) == 0) begin
                    zm  = (zm & ~pair) | yel;
                    zst = spza_pkg::ZS_YELLOW;
                end
            end else begin
                zm = (zm & ~pair) | yel;
                if ((zm & spza_pkg::RED_BITS) == 0) zst = spza_pkg::ZS_YELLOW;
            end
        end else if (s < a5) begin
            zm  = zm | red;
            zst = spza_pkg::ZS_RED;
        end else begin
            zm = zm & ~pair;
            if (zm == 0) zst = spza_pkg::ZS_WHITE;
        end
        if ((zm & spza_pkg::RED_BITS) != 0) begin
            r.alert = 1'b1; r.led_red = spza_pkg::LED_FULL; r.led_green = spza_pkg::LED_OFF;
        end else if ((zm & spza_pkg::YELLOW_BITS) != 0) begin
            r.alert = 1'b0; r.led_red = spza_pkg::LED_FULL; r.led_green = spza_pkg::LED_HALF;
        end else begin
            r.alert = 1'b0; r.led_red = spza_pkg::LED_OFF; r.led_green = spza_pkg::LED_OFF;
        end
        r.zone_mask  = zm;
        r.zone_state = zst;
        return r;
    endfunction

    // samples biased towards the thresholds so that window means cross them
    function automatic logic [spza_pkg::RANGE_W-1:0] pick_range(
        input logic [spza_pkg::DIR_W-1:0] d);
        int a, l, v, sel;
        a   = (d == spza_pkg::DIR_FRONT) ? cfg_front : cfg_side;
        l   = cfg_limit;
        sel = $urandom_range(9);
        if (sel < 3) v = $urandom_range(spza_pkg::RANGE_MAX);
        else if (sel < 5) v = a + int'($urandom_range(80)) - 40;
        else if (sel < 7) v = l + int'($urandom_range(80)) - 40;
        else if (sel < 8) v = ($urandom_range(1) != 0) ? spza_pkg::RANGE_MAX : 0;
        else v = $urandom_range(a, l);
        if (v < 0) v = 0;
        if (v > spza_pkg::RANGE_MAX) v = spza_pkg::RANGE_MAX;
        return v[spza_pkg::RANGE_W-1:0];
    endfunction

    task automatic add_row(input logic [spza_pkg::DIR_W-1:0] d,
                           input logic [spza_pkg::RANGE_W-1:0] r,
                           input bit fx, input spza_pkg::t_out_word res);
        t_row row;
        row.dir = d; row.rng = r; row.fixed = fx; row.res = res;
        dir_rows[n_rows] = row;
        n_rows++;
    endtask

    // entered and left at a falling edge
    task automatic send_word(input logic [spza_pkg::DIR_W-1:0] d,
                             input logic [spza_pkg::RANGE_W-1:0] r,
                             input bit fx, input spza_pkg::t_out_word res);
        while ($urandom_range(99) < snd_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_word    <= '{direction: d, range_mm: r};
        row_fixed = fx;
        row_res   = res;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic cfg_set(input int f, input int s, input int l);
        i_valid <= 1'b0;
        while (exp_cnt != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= spza_pkg::CFG_FRONT_ALERT;
        i_cfg_data <= f[spza_pkg::RANGE_W-1:0];
        @(negedge i_clk);
        i_cfg_idx  <= spza_pkg::CFG_SIDE_ALERT;
        i_cfg_data <= s[spza_pkg::RANGE_W-1:0];
        @(negedge i_clk);
        i_cfg_idx  <= spza_pkg::CFG_RANGE_LIMIT;
        i_cfg_data <= l[spza_pkg::RANGE_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < rcv_pct);
    end

    always @(posedge i_clk) begin
        spza_pkg::t_out_word want;
        if (!i_rst_n) begin
            zone_reset();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    spza_pkg::CFG_FRONT_ALERT: cfg_front = i_cfg_data;
                    spza_pkg::CFG_SIDE_ALERT:  cfg_side  = i_cfg_data;
                    spza_pkg::CFG_RANGE_LIMIT: cfg_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                n_checked++;
                if (exp_cnt == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("ERROR: unexpected result word, mask %02h state %0d",
                                 o_word.zone_mask, o_word.zone_state);
                end else begin
                    want    = exp_mem[exp_rd];
                    exp_rd  = exp_rd + EXP_AW'(1);
                    exp_cnt--;
                    if (o_word.alert !== want.alert || o_word.led_red !== want.led_red ||
                        o_word.led_green !== want.led_green ||
                        o_word.zone_mask !== want.zone_mask ||
                        o_word.zone_state !== want.zone_state) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"ERROR: result %0d exp alert %0d red %0d green %0d ",
                                      "mask %02h state %0d, got %0d %0d %0d %02h %0d"},
                                     n_checked, want.alert, want.led_red, want.led_green,
                                     want.zone_mask, want.zone_state, o_word.alert,
                                     o_word.led_red, o_word.led_green, o_word.zone_mask,
                                     o_word.zone_state);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                want = zone_predict(i_word);
                if (row_fixed) want = row_res;
                exp_mem[exp_wr] = want;
                exp_wr  = exp_wr + EXP_AW'(1);
                exp_cnt++;
                n_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) wd_cnt = 0;
            else wd_cnt++;
            if (wd_cnt >= WD_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles", WD_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int p, k;
        int unsigned pick;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_word     = '0;
        i_stall    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = spza_pkg::CFG_FRONT_ALERT;
        i_cfg_data = '0;
        row_fixed  = 1'b0;
        row_res    = '0;
        snd_pct    = 34;
        rcv_pct    = 56;
        n_taken    = 0;
        n_checked  = 0;
        n_bad      = 0;
        wd_cnt     = 0;
        exp_wr     = '0;
        exp_rd     = '0;
        exp_cnt    = 0;
        n_rows     = 0;
        dir_cur    = spza_pkg::DIR_FRONT;

        // partial window reads as the limit, then an all-zero front window goes red
        repeat (4) add_row(spza_pkg::DIR_FRONT, 12'd0, 1'b1, RES_WHITE);
        add_row(spza_pkg::DIR_FRONT, 12'd0, 1'b1, RES_FRONT_RED);
        // front leaves red for yellow
        add_row(spza_pkg::DIR_FRONT, 12'd4095, 1'b0, '0);
        // mean equal to the limit, then equal to the alert threshold
        repeat (5) add_row(DIR_RIGHT, 12'd1000, 1'b0, '0);
        repeat (5) add_row(DIR_REAR, 12'd150, 1'b0, '0);
        repeat (3) add_row(DIR_LEFT, 12'd4095, 1'b0, '0);
        repeat (4) add_row(DIR_LEFT, 12'd0, 1'b0, '0);
        add_row(DIR_RIGHT, 12'd0, 1'b0, '0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (k = 0; k < n_rows; k++)
            send_word(dir_rows[k].dir, dir_rows[k].rng, dir_rows[k].fixed, dir_rows[k].res);

        for (p = 0; p < N_PHASES; p++) begin
            case (p / 2)
                0:       begin snd_pct = 34; rcv_pct = 56; end
                1:       begin snd_pct = 56; rcv_pct = 34; end
                default: begin snd_pct = 0;  rcv_pct = 0;  end
            endcase
            case (p)
                1: cfg_set(spza_pkg::RANGE_MAX, spza_pkg::RANGE_MAX, 0);
                2: cfg_set(0, 0, spza_pkg::RANGE_MAX);
                3: cfg_set($urandom_range(spza_pkg::RANGE_MAX),
                           $urandom_range(spza_pkg::RANGE_MAX),
                           $urandom_range(spza_pkg::RANGE_MAX));
                4: cfg_set($urandom_range(1500), $urandom_range(600),
                           $urandom_range(3000, 300));
                5: cfg_set($urandom_range(1200), $urandom_range(400),
                           $urandom_range(2500, 400));
                default: ;
            endcase
            for (k = 0; k < PHASE_N; k++) begin
                if ($urandom_range(9) < 4) begin
                    pick    = $urandom_range(3);
                    dir_cur = pick[spza_pkg::DIR_W-1:0];
                end
                send_word(dir_cur, pick_range(dir_cur), 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        while (exp_cnt != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (exp_cnt != 0) n_bad++;

        $display("%0d words sent and %0d results checked over %0d threshold settings,",
                 n_taken, n_checked, N_PHASES);
        $display("with sender and receiver gaps in three patterns; %0d mismatches", n_bad);
        if (n_bad == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spza_pkg.sv
rtl/spza_window.sv
rtl/spza_zone.sv
rtl/sonar_proximity_zone_alarm_top.sv
sim/sonar_proximity_zone_alarm_top_tb.sv
